/* hw/rtl/assert_macros.svh */
// Assertion helpers; clk_i and rst_ni must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge out of reset.
`define RPB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rpb assertion failed");

// Antecedent implies consequent on the following edge.
`define RPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpb assertion failed");

`endif

/* hw/rtl/rpb_pkg.sv */
package rpb_pkg;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned AddrW  = $clog2(MaxLen);
  localparam int unsigned LenW   = 11;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CharW  = 7;
  localparam logic [LenW-1:0] MinLen   = LenW'(12);
  localparam logic [LenW-1:0] MaxLenC  = LenW'(MaxLen);
  localparam logic [LenW-1:0] MinRounds = LenW'(2);
  localparam logic [LenW-1:0] AllChars = LenW'(94);

  typedef enum logic [0:0] {
    PH_FILL = 1'b0,
    PH_SHUF = 1'b1
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_RD1,
    ST_RD2,
    ST_WRV,
    ST_EMIT1,
    ST_EMIT2
  } state_e;

  // word queue head as seen by the back end
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } word_beat_t;

  localparam logic [CharW-1:0] Sym [32] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h2D, 7'h3D, 7'h5B, 7'h5D,
    7'h7B, 7'h7D, 7'h7C, 7'h3B, 7'h3A, 7'h2C, 7'h2E, 7'h3C,
    7'h3E, 7'h3F, 7'h2F, 7'h7E, 7'h60, 7'h27, 7'h22, 7'h5C
  };

  function automatic logic [CharW-1:0] char_at(input logic [6:0] k);
    logic [6:0] s;
    s = k - 7'd62;
    if (k < 7'd10)      return 7'h30 + k;
    else if (k < 7'd36) return 7'h61 + (k - 7'd10);
    else if (k < 7'd62) return 7'h41 + (k - 7'd36);
    else                return Sym[s[4:0]];
  endfunction

  function automatic logic [LenW-1:0] cat_size(input logic [1:0] c);
    case (c)
      2'd0:    return LenW'(10);
      2'd1:    return LenW'(26);
      2'd2:    return LenW'(26);
      default: return LenW'(32);
    endcase
  endfunction

  function automatic logic [6:0] cat_base(input logic [1:0] c);
    case (c)
      2'd0:    return 7'd0;
      2'd1:    return 7'd10;
      2'd2:    return 7'd36;
      default: return 7'd62;
    endcase
  endfunction

endpackage

/* hw/rtl/random_password_builder_shuffle.sv */
// Channel  | Dir | Signals                         | Content
// s_axis   | in  | s_tvalid_i/s_tready_o/s_tdata_i | entropy words
// m_axis   | out | m_tvalid_o/m_tready_i/m_tdata_o | password chars, tlast on final
// cfg      | in  | cfg_we_i/cfg_wdata_i            | password_length
// Each beat runs through the 32-step restoring remainder unit and a check step; shuffle
// beats then add store read/write and emit steps.
// A four-deep word queue keeps accepting beats while the back end divides, until it is full.
// Reset is asynchronous, active low; the character store needs no clearing.
// Output stalls hold the sequencer in its emit step; a two-entry queue buffers.
module random_password_builder_shuffle (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [31:0]                   s_tdata_i,   // [31:0] random_word
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [7:0]                    m_tdata_o,   // [6:0] out_char, [7] zero
  output logic                          m_tlast_o,   // last_char
  input  logic                          cfg_we_i,
  input  logic [rpb_pkg::LenW-1:0]      cfg_wdata_i  // password_length
);
  rpb_pkg::word_beat_t head;
  logic pop;
  logic [rpb_pkg::CharW-1:0] ch;

  // front: accept and queue entropy beats
  rpb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: rejection draw, fill, shuffle, emit
  rpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_char_o    (ch),
    .m_last_o    (m_tlast_o)
  );

  assign m_tdata_o = {1'b0, ch};
endmodule

/* hw/rtl/rpb_front.sv */
module rpb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [rpb_pkg::WordW-1:0]      s_tdata_i,
  output rpb_pkg::word_beat_t            head_o,
  input  logic                           pop_i
);
  // four-deep word queue
  logic [rpb_pkg::WordW-1:0] buf_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic push, pop;

  assign s_tready_o = (cnt_q != 3'd4);
  assign push = s_tvalid_i && s_tready_o;
  assign pop  = pop_i && (cnt_q != 3'd0);
  assign head_o.valid = (cnt_q != 3'd0);
  assign head_o.word  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= s_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
    end
  end
endmodule

/* hw/rtl/rpb_back.sv */
`include "assert_macros.svh"
module rpb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpb_pkg::LenW-1:0]       cfg_wdata_i,
  input  rpb_pkg::word_beat_t            head_i,
  output logic                           pop_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [rpb_pkg::CharW-1:0]      m_char_o,
  output logic                           m_last_o
);
  localparam int unsigned AW = rpb_pkg::AddrW;
  localparam int unsigned LW = rpb_pkg::LenW;
  localparam int unsigned CW = rpb_pkg::CharW;

  rpb_pkg::state_e state_q, state_d;
  rpb_pkg::phase_e phase_q;
  logic [LW-1:0] cfg_len_q, fill_q, idx_q, alen_q, n_q, rem_q;
  logic [1:0]    slot_q;
  logic [31:0]   word_q, sh_q;
  logic [6:0]    base_q;
  logic          incat_q;
  logic [4:0]    dcnt_q;
  logic [CW-1:0] rdata_q, rv_q, ro_q;

  // store
  logic [CW-1:0] mem [rpb_pkg::MaxLen];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [CW-1:0] mem_wd;

  // output queue
  logic [CW-1:0] oc_q [2];
  logic          ol_q [2];
  logic          owp_q, orp_q;
  logic [1:0]    ocnt_q;
  logic          opush, opop, olast;
  logic [CW-1:0] ochar;

  // front-of-item classification
  logic [LW-1:0] len_c, alen_use, rounds, n_c;
  logic          incat_c;
  logic [LW:0]   trial;
  logic [32:0]   chk;
  logic          accept, last_fill, one;

  always_comb begin
    len_c = cfg_len_q;
    if (len_c < rpb_pkg::MinLen) len_c = rpb_pkg::MinLen;
    if (len_c > rpb_pkg::MaxLenC) len_c = rpb_pkg::MaxLenC;
    alen_use = (fill_q == '0) ? len_c : alen_q;
    rounds = alen_use >> 3;
    if (rounds < rpb_pkg::MinRounds) rounds = rpb_pkg::MinRounds;
    incat_c = fill_q < {rounds[LW-3:0], 2'b00};
    if (phase_q == rpb_pkg::PH_SHUF) n_c = idx_q + LW'(1);
    else n_c = incat_c ? rpb_pkg::cat_size(slot_q) : rpb_pkg::AllChars;
  end

  assign trial     = {rem_q, sh_q[31]};
  assign chk       = {1'b0, word_q} - {22'd0, rem_q} + {22'd0, n_q};
  assign accept    = (chk <= 33'h0FFFFFFFF);
  assign last_fill = (fill_q + LW'(1)) >= alen_q;
  assign one       = (idx_q == LW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpb_pkg::ST_IDLE:  if (head_i.valid) state_d = rpb_pkg::ST_DIV;
      rpb_pkg::ST_DIV:   if (dcnt_q == 5'd31) state_d = rpb_pkg::ST_CHECK;
      rpb_pkg::ST_CHECK: begin
        if (accept && phase_q == rpb_pkg::PH_SHUF) state_d = rpb_pkg::ST_RD1;
        else state_d = rpb_pkg::ST_IDLE;
      end
      rpb_pkg::ST_RD1:   state_d = rpb_pkg::ST_RD2;
      rpb_pkg::ST_RD2:   state_d = one ? rpb_pkg::ST_EMIT1 : rpb_pkg::ST_WRV;
      rpb_pkg::ST_WRV:   state_d = rpb_pkg::ST_EMIT1;
      rpb_pkg::ST_EMIT1: begin
        if (ocnt_q != 2'd2) state_d = one ? rpb_pkg::ST_EMIT2 : rpb_pkg::ST_IDLE;
      end
      rpb_pkg::ST_EMIT2: if (ocnt_q != 2'd2) state_d = rpb_pkg::ST_IDLE;
      default:           state_d = rpb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o  = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = idx_q[AW-1:0];
    mem_ra = rem_q[AW-1:0];
    mem_wd = rv_q;
    opush  = 1'b0;
    ochar  = rv_q;
    olast  = 1'b0;
    case (state_q)
      rpb_pkg::ST_IDLE: pop_o = head_i.valid;
      rpb_pkg::ST_CHECK: begin
        if (accept) begin
          if (phase_q == rpb_pkg::PH_SHUF) begin
            mem_re = 1'b1;
          end else begin
            mem_we = 1'b1;
            mem_wa = fill_q[AW-1:0];
            mem_wd = rpb_pkg::char_at(base_q + rem_q[6:0]);
          end
        end
      end
      rpb_pkg::ST_RD1: begin
        mem_re = 1'b1;
        mem_ra = one ? (rem_q[AW-1:0] ^ AW'(1)) : idx_q[AW-1:0];
      end
      rpb_pkg::ST_RD2: mem_we = !one;
      rpb_pkg::ST_WRV: begin
        mem_we = 1'b1;
        mem_wa = rem_q[AW-1:0];
        mem_wd = ro_q;
      end
      rpb_pkg::ST_EMIT1: opush = (ocnt_q != 2'd2);
      rpb_pkg::ST_EMIT2: begin
        opush = (ocnt_q != 2'd2);
        ochar = ro_q;
        olast = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      rpb_pkg::ST_IDLE: begin
        word_q  <= head_i.word;
        sh_q    <= head_i.word;
        n_q     <= n_c;
        base_q  <= incat_c ? rpb_pkg::cat_base(slot_q) : 7'd0;
        incat_q <= incat_c;
      end
      rpb_pkg::ST_DIV: begin
        sh_q <= {sh_q[30:0], 1'b0};
        if (trial >= {1'b0, n_q}) rem_q <= LW'(trial - {1'b0, n_q});
        else rem_q <= trial[LW-1:0];
      end
      rpb_pkg::ST_RD1: rv_q <= rdata_q;
      rpb_pkg::ST_RD2: ro_q <= rdata_q;
      default: ;
    endcase
    if (state_q == rpb_pkg::ST_IDLE) rem_q <= '0;
    if (opush) begin
      oc_q[owp_q] <= ochar;
      ol_q[owp_q] <= olast;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rpb_pkg::ST_IDLE;
      phase_q   <= rpb_pkg::PH_FILL;
      cfg_len_q <= rpb_pkg::MinLen;
      fill_q    <= '0;
      idx_q     <= '0;
      slot_q    <= '0;
      alen_q    <= rpb_pkg::MinLen;
      dcnt_q    <= '0;
      owp_q     <= 1'b0;
      orp_q     <= 1'b0;
      ocnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_len_q <= cfg_wdata_i;
      dcnt_q <= (state_q == rpb_pkg::ST_DIV) ? dcnt_q + 5'd1 : 5'd0;
      if (state_q == rpb_pkg::ST_IDLE && head_i.valid && phase_q == rpb_pkg::PH_FILL)
        alen_q <= alen_use;
      if (state_q == rpb_pkg::ST_CHECK && accept && phase_q == rpb_pkg::PH_FILL) begin
        fill_q <= fill_q + LW'(1);
        if (incat_q) slot_q <= slot_q + 2'd1;
        if (last_fill) begin
          phase_q <= rpb_pkg::PH_SHUF;
          idx_q   <= alen_q - LW'(1);
        end
      end
      if (state_q == rpb_pkg::ST_EMIT1 && opush && !one) idx_q <= idx_q - LW'(1);
      if (state_q == rpb_pkg::ST_EMIT2 && opush) begin
        phase_q <= rpb_pkg::PH_FILL;
        fill_q  <= '0;
        slot_q  <= '0;
        idx_q   <= '0;
      end
      if (opush) owp_q <= ~owp_q;
      if (opop) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  assign m_tvalid_o = (ocnt_q != 2'd0);
  assign opop       = m_tvalid_o && m_tready_i;
  assign m_char_o   = oc_q[orp_q];
  assign m_last_o   = ol_q[orp_q];

  `RPB_ASSERT(a_ocnt_max, ocnt_q <= 2'd2)
  `RPB_ASSERT(a_emit_shuf, (state_q != rpb_pkg::ST_EMIT1) || (phase_q == rpb_pkg::PH_SHUF))
  `RPB_ASSERT(a_fill_bound, (phase_q != rpb_pkg::PH_FILL) || (fill_q < alen_q) || (fill_q == '0))
  `RPB_ASSERT_NEXT(a_div_len, state_q == rpb_pkg::ST_DIV && dcnt_q != 5'd31,
                   state_q == rpb_pkg::ST_DIV)
endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainWait  = 200;   // a few beats' worth of divider time
  localparam int unsigned ItemTarget = 1150;

  // printable symbols, in charset order after the 62 letters and digits
  localparam string SymChars = "!@#$%^&*()_+-=[]{}|;:,.<>?/~`'\"\\";

  typedef struct {
    logic [rpb_pkg::CharW-1:0] ch;
    logic                      last;
  } pw_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [31:0] s_tdata_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;
  logic m_tlast_o;
  logic cfg_we_i = 1'b0;
  logic [rpb_pkg::LenW-1:0] cfg_wdata_i = '0;

  random_password_builder_shuffle dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),    // [31:0] random_word
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),    // [6:0] out_char, [7] zero
    .m_tlast_o   (m_tlast_o),    // last_char
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)   // password_length
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Password predictor: own copy of length register and builder state.
  // ---------------------------------------------------------------------
  logic [rpb_pkg::CharW-1:0] pw_store [rpb_pkg::MaxLen];
  int unsigned req_len = 12;
  int unsigned cur_len = 12;
  int unsigned fill_n = 0;
  int unsigned shuf_i = 0;
  int unsigned cat_n = 0;
  rpb_pkg::phase_e pw_phase = rpb_pkg::PH_FILL;
  bit          pw_done;
  int unsigned used_words = 0;

  pw_char_t    exp_chars [$];
  logic [31:0] word_q [$];
  int unsigned fail_cnt = 0;

  function automatic int unsigned clamp_length(int unsigned v);
    if (v < 12) return 12;
    if (v > rpb_pkg::MaxLen) return rpb_pkg::MaxLen;
    return v;
  endfunction

  // character code of index 0..93 of the full set
  function automatic logic [rpb_pkg::CharW-1:0] code_of(int unsigned k);
    if (k < 10) return rpb_pkg::CharW'(8'h30 + k);
    if (k < 36) return rpb_pkg::CharW'(8'h61 + k - 10);
    if (k < 62) return rpb_pkg::CharW'(8'h41 + k - 36);
    return rpb_pkg::CharW'(SymChars[k - 62]);
  endfunction

  function automatic void pw_restart();
    pw_phase = rpb_pkg::PH_FILL;
    fill_n   = 0;
    cat_n    = 0;
    shuf_i   = 0;
    pw_done  = 1'b1;
  endfunction

  // advance the predictor by one entropy word, queue any chars it finishes
  function automatic void predict_word(logic [31:0] w);
    int unsigned rounds, n, base, v, i;
    logic [31:0] lim;
    logic [rpb_pkg::CharW-1:0] tmp;
    bit in_cat;
    used_words++;
    if (pw_phase != rpb_pkg::PH_SHUF) begin
      if (fill_n == 0) cur_len = clamp_length(req_len);
      rounds = cur_len / 8;
      if (rounds < 2) rounds = 2;
      in_cat = fill_n < rounds * 4;
      case (cat_n)
        0:       begin n = 10; base = 0;  end
        1:       begin n = 26; base = 10; end
        2:       begin n = 26; base = 36; end
        default: begin n = 32; base = 62; end
      endcase
      if (!in_cat) begin
        n = 94;
        base = 0;
      end
      lim = 32'hFFFF_FFFF - (32'hFFFF_FFFF % n);
      if (w >= lim) return;             // rejected word: nothing changes
      v = w % n;
      pw_store[fill_n] = code_of(base + v);
      fill_n++;
      if (in_cat) cat_n = (cat_n + 1) % 4;
      if (fill_n >= cur_len) begin
        pw_phase = rpb_pkg::PH_SHUF;
        shuf_i = cur_len - 1;
      end
      return;
    end
    i = shuf_i;
    lim = 32'hFFFF_FFFF - (32'hFFFF_FFFF % (i + 1));
    if (w >= lim) return;
    v = w % (i + 1);
    tmp = pw_store[i];
    pw_store[i] = pw_store[v];
    pw_store[v] = tmp;
    exp_chars.push_back('{ch: pw_store[i], last: 1'b0});
    if (i == 1) begin
      exp_chars.push_back('{ch: pw_store[0], last: 1'b1});
      pw_restart();
    end else begin
      shuf_i = i - 1;
    end
  endfunction

  // mostly uniform words, some near the top to hit the rejection band
  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 99) < 12) return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00);
    return $urandom;
  endfunction

  // queue words until the predictor has finished the current password
  task automatic queue_password();
    pw_done = 1'b0;
    while (!pw_done) begin
      logic [31:0] w;
      w = rand_word();
      word_q.push_back(w);
      predict_word(w);
    end
  endtask

  task automatic wait_idle();
    wait (word_q.size() == 0 && exp_chars.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_length(int unsigned len);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rpb_pkg::LenW'(len);
    req_len = len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  logic [31:0] directed_words [10] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'hFFFF_FFFA, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000
  };
  int unsigned len_plan [8] = '{12, 0, 13, 16, 24, 100, 31, 40};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length: extreme words, rejection edges, then finish the password
    foreach (directed_words[k]) begin
      word_q.push_back(directed_words[k]);
      predict_word(directed_words[k]);
    end
    if (pw_phase == rpb_pkg::PH_FILL && fill_n == 0) pw_done = 1'b1;
    else queue_password();

    // below-min, odd and round-boundary lengths
    foreach (len_plan[k]) begin
      write_length(len_plan[k]);
      queue_password();
    end

    // mostly short passwords, occasional longer ones
    while (used_words < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) write_length($urandom_range(0, 120));
      else write_length($urandom_range(0, 40));
      queue_password();
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("[random_password_builder_shuffle] OK");
    end else begin
      $display("[random_password_builder_shuffle] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts with random gaps, holds a beat until it is taken
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) void'(word_q.pop_front());
      if (!(s_tvalid_i && !s_tready_o)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid_i <= 1'b0;
        end else if (word_q.size() > 0) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= word_q[0];
          burst_left--;
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long receiver hold-off so the word queue fills and s_tready drops;
  // starts once chars flow and at least 16 words are still queued
  // ---------------------------------------------------------------------
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        hold_r = 1'b0;

  always @(posedge clk_i) begin
    if (!hold_done && m_tvalid_o && m_tready_i && word_q.size() >= 16) begin
      hold_left = 5_000;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    hold_r <= (hold_left > 0);
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each char beat, stalls on its own pattern
  // ---------------------------------------------------------------------
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  bit          rx_ready;

  always @(posedge clk_i) begin
    pw_char_t e;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        if (exp_chars.size() == 0) begin
          $error("unexpected char beat: out_char %0h last_char %0b", m_tdata_o[6:0], m_tlast_o);
          fail_cnt++;
        end else begin
          e = exp_chars.pop_front();
          if (m_tdata_o[6:0] !== e.ch) begin
            $error("out_char: expected %0h actual %0h", e.ch, m_tdata_o[6:0]);
            fail_cnt++;
          end
          if (m_tlast_o !== e.last) begin
            $error("last_char: expected %0b actual %0b", e.last, m_tlast_o);
            fail_cnt++;
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       rx_ready = 1'b1;
        1:       rx_ready = $urandom_range(0, 1);
        2:       rx_ready = ($urandom_range(0, 3) == 0);
        default: rx_ready = rx_mode_left[0];
      endcase
      m_tready_i <= rx_ready && !hold_r;
    end
  end

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("[random_password_builder_shuffle] ERROR");
      $finish;
    end
  end

endmodule

/* random_password_builder_shuffle.f */
+incdir+hw/rtl
hw/rtl/rpb_pkg.sv
hw/rtl/rpb_front.sv
hw/rtl/rpb_back.sv
hw/rtl/random_password_builder_shuffle.sv
sim/testbench.sv
